// ----- sv/dda_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the DDA line rasterizer.
// No dependencies; every other file of the block imports this package.

package dda_pkg;

	localparam int RGB_W = 24;

	typedef logic [RGB_W-1:0] rgb_t;

	// Color after reset: pure green
	localparam rgb_t RGB_RESET = 24'h00FF00;

endpackage

// ----- sv/dda_front.sv -----
`timescale 1ns / 1ps
// Front end of the DDA line rasterizer: takes a line request, finds the step
// count and works out the minor-axis per-step increment with a bit-serial
// divider; the major axis steps by one pixel. Depends on dda_pkg.

module dda_front #(
	parameter int COORD_BITS = 6,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// line requests
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COORD_BITS-1:0]   start_x,
	input  logic [COORD_BITS-1:0]   start_y,
	input  logic [COORD_BITS-1:0]   end_x,
	input  logic [COORD_BITS-1:0]   end_y,
	// prepared jobs toward the queue
	output logic                    job_valid,
	input  logic                    job_full,
	output logic [COORD_BITS-1:0]   job_x0,
	output logic [COORD_BITS-1:0]   job_y0,
	output logic [COORD_BITS-1:0]   job_count,
	output logic [FRAC_BITS+1:0]    job_inc_x,
	output logic [FRAC_BITS+1:0]    job_inc_y
);

	import dda_pkg::*;

	localparam int SPAN_W = COORD_BITS + 1;
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int INC_W  = FRAC_BITS + 2;
	localparam int BIT_W  = $clog2(FRAC_BITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t                  state_q;
	logic [BIT_W-1:0]        bit_q;
	logic [SPAN_W-1:0]       rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic [COORD_BITS-1:0]   x0_q;
	logic [COORD_BITS-1:0]   y0_q;
	logic [COORD_BITS-1:0]   count_q;
	logic                    neg_x_q;
	logic                    neg_y_q;
	logic                    x_major_q;

	logic                    accept;
	logic [SPAN_W-1:0]       span_x;
	logic [SPAN_W-1:0]       span_y;
	logic [SPAN_W-1:0]       abs_x;
	logic [SPAN_W-1:0]       abs_y;
	logic                    x_major;
	logic [COORD_BITS-1:0]   count_new;
	logic [COORD_BITS-1:0]   minor_new;
	logic                    int_bit;
	logic [SPAN_W-1:0]       rem_shift;
	logic                    quo_bit;
	logic [QUO_W-1:0]        mag_x;
	logic [QUO_W-1:0]        mag_y;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		span_x    = {1'b0, end_x} - {1'b0, start_x};
		span_y    = {1'b0, end_y} - {1'b0, start_y};
		abs_x     = span_x[SPAN_W-1] ? -span_x : span_x;
		abs_y     = span_y[SPAN_W-1] ? -span_y : span_y;
		x_major   = (abs_x >= abs_y);
		count_new = x_major ? abs_x[COORD_BITS-1:0] : abs_y[COORD_BITS-1:0];
		minor_new = x_major ? abs_y[COORD_BITS-1:0] : abs_x[COORD_BITS-1:0];
		// integer bit of minor/count: 1 only when both spans match
		int_bit   = (minor_new >= count_new);
	end

	// one restoring division step per cycle
	always_comb begin
		rem_shift = {rem_q[SPAN_W-2:0], 1'b0};
		quo_bit   = (rem_shift >= {1'b0, count_q});
	end

	// the major axis steps by exactly one pixel
	always_comb begin
		mag_x = x_major_q ? (QUO_W'(1) << FRAC_BITS) : quo_q;
		mag_y = x_major_q ? quo_q : (QUO_W'(1) << FRAC_BITS);
	end

	assign job_valid = (state_q == ST_HOLD);
	assign job_x0    = x0_q;
	assign job_y0    = y0_q;
	assign job_count = count_q;
	assign job_inc_x = neg_x_q ? -{1'b0, mag_x} : {1'b0, mag_x};
	assign job_inc_y = neg_y_q ? -{1'b0, mag_y} : {1'b0, mag_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_DIV;
						bit_q     <= '0;
						x0_q      <= start_x;
						y0_q      <= start_y;
						count_q   <= count_new;
						neg_x_q   <= span_x[SPAN_W-1];
						neg_y_q   <= span_y[SPAN_W-1];
						x_major_q <= x_major;
						quo_q     <= {{(QUO_W-1){1'b0}}, int_bit};
						rem_q     <= {1'b0, minor_new} - (int_bit ? {1'b0, count_new} : '0);
					end
				end
				ST_DIV: begin
					quo_q <= {quo_q[QUO_W-2:0], quo_bit};
					rem_q <= quo_bit ? (rem_shift - {1'b0, count_q}) : rem_shift;
					bit_q <= bit_q + BIT_W'(1);
					if (bit_q == BIT_W'(FRAC_BITS - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					// hold the job until the queue has room
					if (!job_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && bit_q == BIT_W'(FRAC_BITS - 1)) |=> (state_q == ST_HOLD))
		else $error("divider did not finish after the last quotient bit");

endmodule

// ----- sv/dda_queue.sv -----
`timescale 1ns / 1ps
// Short job queue between the front end and the pixel stepper of the DDA
// line rasterizer. Depends on dda_pkg.

module dda_queue #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	import dda_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	a_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop && cnt_q == CNT_W'(DEPTH - 1)) |=> full)
		else $error("queue count lost a job");

endmodule

// ----- sv/dda_back.sv -----
`timescale 1ns / 1ps
// Pixel stepper of the DDA line rasterizer: runs both fixed-point
// accumulators and emits one pixel per cycle into an output register while
// a line is running and the output is not stalled. Depends on dda_pkg.

module dda_back #(
	parameter int COORD_BITS = 6,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// jobs from the queue
	input  logic                    job_valid,
	output logic                    job_pop,
	input  logic [COORD_BITS-1:0]   job_x0,
	input  logic [COORD_BITS-1:0]   job_y0,
	input  logic [COORD_BITS-1:0]   job_count,
	input  logic [FRAC_BITS+1:0]    job_inc_x,
	input  logic [FRAC_BITS+1:0]    job_inc_y,
	input  dda_pkg::rgb_t           color,
	// pixel requests
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [COORD_BITS-1:0]   pixel_x,
	output logic [COORD_BITS-1:0]   pixel_y,
	output dda_pkg::rgb_t           pixel_rgb,
	output logic                    last_pixel
);

	import dda_pkg::*;

	localparam int INC_W = FRAC_BITS + 2;
	localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;

	logic                    busy_q;
	logic [ACC_W-1:0]        acc_x_q;
	logic [ACC_W-1:0]        acc_y_q;
	logic [ACC_W-1:0]        inc_x_q;
	logic [ACC_W-1:0]        inc_y_q;
	logic [COORD_BITS-1:0]   left_q;
	logic                    out_valid_q;
	logic [COORD_BITS-1:0]   pixel_x_q;
	logic [COORD_BITS-1:0]   pixel_y_q;
	rgb_t                    pixel_rgb_q;
	logic                    last_q;

	logic                    emit;
	logic [ACC_W-1:0]        half;

	assign half    = ACC_W'(1) << (FRAC_BITS - 1);
	assign job_pop = !busy_q && job_valid;
	assign emit    = busy_q && (!out_valid_q || !out_stall);

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign pixel_rgb  = pixel_rgb_q;
	assign last_pixel = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (job_pop) begin
				busy_q  <= 1'b1;
				acc_x_q <= ACC_W'({job_x0, {FRAC_BITS{1'b0}}}) + half;
				acc_y_q <= ACC_W'({job_y0, {FRAC_BITS{1'b0}}}) + half;
				inc_x_q <= {{(ACC_W-INC_W){job_inc_x[INC_W-1]}}, job_inc_x};
				inc_y_q <= {{(ACC_W-INC_W){job_inc_y[INC_W-1]}}, job_inc_y};
				left_q  <= job_count;
			end
			if (emit) begin
				// truncate, clamping a negative accumulator to zero
				pixel_x_q   <= acc_x_q[ACC_W-1] ? '0 : acc_x_q[FRAC_BITS +: COORD_BITS];
				pixel_y_q   <= acc_y_q[ACC_W-1] ? '0 : acc_y_q[FRAC_BITS +: COORD_BITS];
				pixel_rgb_q <= color;
				last_q      <= (left_q == '0);
				acc_x_q     <= acc_x_q + inc_x_q;
				acc_y_q     <= acc_y_q + inc_y_q;
				left_q      <= left_q - COORD_BITS'(1);
				if (left_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && left_q == '0) |=> (out_valid && last_pixel && !busy_q))
		else $error("final pixel of a line not flagged last");

	a_no_early_end: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && left_q != '0) |=> (busy_q && !last_pixel))
		else $error("line ended before its final pixel");

endmodule

// ----- sv/dda_line_rasterizer.sv -----
`timescale 1ns / 1ps
// DDA line rasterizer, top level: front end, job queue and pixel stepper.
// Depends on dda_pkg, dda_front, dda_queue and dda_back.

// A line request from (start_x, start_y) to (end_x, end_y) yields n + 1 pixel
// requests, where n is the larger of the absolute x and y spans, from the
// start point to the end point inclusive; the final one carries last_pixel.
// Every pixel carries the color held in the color_q register (written
// through cfg_we / cfg_wdata, green after reset). The front end takes a new
// request only once its divider, which produces one quotient bit per cycle,
// has finished and the job has gone to the queue. The stepper emits one
// pixel per cycle while the output is not stalled. A two-entry queue lets
// the next line be divided while the current one is drawn.

module dda_line_rasterizer #(
	parameter int COORD_BITS = 6,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  dda_pkg::rgb_t           cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COORD_BITS-1:0]   start_x,
	input  logic [COORD_BITS-1:0]   start_y,
	input  logic [COORD_BITS-1:0]   end_x,
	input  logic [COORD_BITS-1:0]   end_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [COORD_BITS-1:0]   pixel_x,
	output logic [COORD_BITS-1:0]   pixel_y,
	output dda_pkg::rgb_t           pixel_rgb,
	output logic                    last_pixel
);

	import dda_pkg::*;

	localparam int INC_W       = FRAC_BITS + 2;
	localparam int JOB_W       = 3 * COORD_BITS + 2 * INC_W;
	localparam int QUEUE_DEPTH = 2;

	rgb_t                    color_q;

	logic                    f_valid;
	logic                    q_full;
	logic [COORD_BITS-1:0]   f_x0;
	logic [COORD_BITS-1:0]   f_y0;
	logic [COORD_BITS-1:0]   f_count;
	logic [INC_W-1:0]        f_inc_x;
	logic [INC_W-1:0]        f_inc_y;
	logic [JOB_W-1:0]        q_in;

	logic                    q_valid;
	logic                    q_pop;
	logic [JOB_W-1:0]        q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RGB_RESET;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	dda_front #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.job_valid (f_valid),
		.job_full  (q_full),
		.job_x0    (f_x0),
		.job_y0    (f_y0),
		.job_count (f_count),
		.job_inc_x (f_inc_x),
		.job_inc_y (f_inc_y)
	);

	assign q_in = {f_x0, f_y0, f_count, f_inc_x, f_inc_y};

	dda_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (f_valid),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head)
	);

	dda_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (q_valid),
		.job_pop    (q_pop),
		.job_x0     (q_head[JOB_W-1 -: COORD_BITS]),
		.job_y0     (q_head[JOB_W-COORD_BITS-1 -: COORD_BITS]),
		.job_count  (q_head[2*INC_W +: COORD_BITS]),
		.job_inc_x  (q_head[INC_W +: INC_W]),
		.job_inc_y  (q_head[0 +: INC_W]),
		.color      (color_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_rgb  (pixel_rgb),
		.last_pixel (last_pixel)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("front end took a second request while dividing");

endmodule

// ----- tb/tb_dda_line_rasterizer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dda_line_rasterizer: a queue-fed line driver, a pixel
// monitor with random stalls and one long hold-off, and a DDA pixel predictor.
// Depends on dda_pkg and dda_line_rasterizer.

module tb_dda_line_rasterizer;

	import dda_pkg::*;

	localparam int COORD_BITS   = 6;
	localparam int FRAC_BITS    = 16;
	localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
	localparam int LINES_PER_SET = 90;
	localparam int QUIET_FROM   = 4000;
	localparam int QUIET_TO     = 7000;
	localparam int HOLD_AT      = 1500;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 2 * (COORD_MAX + FRAC_BITS + 4);
	localparam int CYCLE_LIMIT  = 400000;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} line_t;

	typedef struct {
		coord_t x;
		coord_t y;
		rgb_t   rgb;
		logic   last;
	} pixel_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_we = 1'b0;
	rgb_t   cfg_wdata = '0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t start_x = '0;
	coord_t start_y = '0;
	coord_t end_x = '0;
	coord_t end_y = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	coord_t pixel_x;
	coord_t pixel_y;
	rgb_t   pixel_rgb;
	logic   last_pixel;

	line_t  pending_lines[$];
	pixel_t expected_pixels[$];
	line_t  line_on_bus;
	rgb_t   color_reg = RGB_RESET;
	int     mismatches = 0;
	int     lines_taken = 0;
	int     pixels_checked = 0;
	int     color_sets = 1;
	int     cycle_count = 0;
	int     hold_left = 0;
	bit     hold_done = 1'b0;

	dda_line_rasterizer #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.pixel_rgb (pixel_rgb),
		.last_pixel(last_pixel)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_dda_line_rasterizer: done, errors");
			$finish;
		end
	end

	// Random gaps on both sides, none inside the quiet window
	function automatic bit take_break();
		if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < 20;
	endfunction

	// Step both accumulators from start + 1/2; the major axis moves by exactly one
	function automatic void rasterize_line(line_t ln, rgb_t color);
		int span_x;
		int span_y;
		int mag_x;
		int mag_y;
		int steps;
		int inc_x;
		int inc_y;
		int acc_x;
		int acc_y;
		pixel_t px;
		span_x = int'(ln.end_x) - int'(ln.start_x);
		span_y = int'(ln.end_y) - int'(ln.start_y);
		mag_x = span_x < 0 ? -span_x : span_x;
		mag_y = span_y < 0 ? -span_y : span_y;
		steps = mag_x > mag_y ? mag_x : mag_y;
		inc_x = 0;
		inc_y = 0;
		if (steps > 0) begin
			inc_x = (mag_x << FRAC_BITS) / steps;
			inc_y = (mag_y << FRAC_BITS) / steps;
			if (span_x < 0)
				inc_x = -inc_x;
			if (span_y < 0)
				inc_y = -inc_y;
		end
		acc_x = (int'(ln.start_x) << FRAC_BITS) + (1 << (FRAC_BITS - 1));
		acc_y = (int'(ln.start_y) << FRAC_BITS) + (1 << (FRAC_BITS - 1));
		for (int k = 0; k <= steps; k++) begin
			px.x = acc_x < 0 ? '0 : coord_t'(acc_x >>> FRAC_BITS);
			px.y = acc_y < 0 ? '0 : coord_t'(acc_y >>> FRAC_BITS);
			px.rgb = color;
			px.last = (k == steps);
			expected_pixels.push_back(px);
			acc_x += inc_x;
			acc_y += inc_y;
		end
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return coord_t'(COORD_MAX);
		return coord_t'(v);
	endfunction

	function automatic coord_t edge_coord();
		case ($urandom_range(2))
			0: return '0;
			1: return coord_t'(COORD_MAX);
			default: return coord_t'($urandom_range(COORD_MAX));
		endcase
	endfunction

	// Mix of uniform lines, short lines (zero length among them) and border lines
	function automatic line_t random_line();
		line_t ln;
		int pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			ln.start_x = coord_t'($urandom_range(COORD_MAX));
			ln.start_y = coord_t'($urandom_range(COORD_MAX));
			ln.end_x = clamp_coord(int'(ln.start_x) + int'($urandom_range(8)) - 4);
			ln.end_y = clamp_coord(int'(ln.start_y) + int'($urandom_range(8)) - 4);
		end else if (pick < 40) begin
			ln.start_x = edge_coord();
			ln.start_y = edge_coord();
			ln.end_x = edge_coord();
			ln.end_y = edge_coord();
		end else begin
			ln.start_x = coord_t'($urandom_range(COORD_MAX));
			ln.start_y = coord_t'($urandom_range(COORD_MAX));
			ln.end_x = coord_t'($urandom_range(COORD_MAX));
			ln.end_y = coord_t'($urandom_range(COORD_MAX));
		end
		return ln;
	endfunction

	task automatic queue_line(int sx, int sy, int ex, int ey);
		line_t ln;
		ln.start_x = coord_t'(sx);
		ln.start_y = coord_t'(sy);
		ln.end_x = coord_t'(ex);
		ln.end_y = coord_t'(ey);
		pending_lines.push_back(ln);
	endtask

	task automatic wait_idle();
		while (pending_lines.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (FRAC_BITS + 4) @(posedge clk);
	endtask

	task automatic write_color(rgb_t value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		color_reg = value;
		color_sets++;
	endtask

	// Line driver: predict on acceptance, then offer the next request or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				rasterize_line(line_on_bus, color_reg);
				lines_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_lines.size() != 0 && !take_break()) begin
					line_on_bus = pending_lines.pop_front();
					in_valid <= 1'b1;
					start_x <= line_on_bus.start_x;
					start_y <= line_on_bus.start_y;
					end_x <= line_on_bus.end_x;
					end_y <= line_on_bus.end_y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Pixel monitor: check against the oldest expectation, stall at random
	always @(posedge clk) begin
		pixel_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected pixel (%0d, %0d)", pixel_x, pixel_y);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("pixel_x", want.x, pixel_x);
					check_field("pixel_y", want.y, pixel_y);
					check_field("pixel_rgb", want.rgb, pixel_rgb);
					check_field("last_pixel", want.last, last_pixel);
					pixels_checked++;
				end
			end
			// Hold off long enough for the block to back up into its input
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && pixels_checked >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= take_break();
			end
		end
	end

	initial begin
		rgb_t colors[4];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines under the reset color
		queue_line(0, 0, 0, 0);
		queue_line(63, 63, 63, 63);
		queue_line(17, 42, 17, 42);
		queue_line(0, 0, 63, 0);
		queue_line(63, 5, 0, 5);
		queue_line(7, 0, 7, 63);
		queue_line(40, 63, 40, 0);
		queue_line(0, 0, 63, 63);
		queue_line(63, 0, 0, 63);
		queue_line(0, 63, 63, 0);
		queue_line(63, 63, 0, 0);
		queue_line(0, 0, 63, 1);
		queue_line(0, 0, 1, 63);
		queue_line(5, 10, 50, 20);
		queue_line(60, 3, 2, 40);
		queue_line(10, 50, 13, 2);
		queue_line(31, 31, 32, 32);
		queue_line(31, 31, 30, 31);
		queue_line(21, 42, 42, 21);
		queue_line(42, 21, 21, 42);
		queue_line(0, 32, 63, 31);
		wait_idle();

		colors[0] = '0;
		colors[1] = '1;
		colors[2] = rgb_t'($urandom);
		colors[3] = rgb_t'($urandom);
		foreach (colors[i]) begin
			write_color(colors[i]);
			repeat (LINES_PER_SET) pending_lines.push_back(random_line());
			wait_idle();
		end

		// Catch stray pixels after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			$error("%0d expected pixels never arrived", expected_pixels.size());
			mismatches++;
		end
		$display("Drew %0d lines (%0d pixels checked) under %0d color settings,",
			lines_taken, pixels_checked, color_sets);
		$display("with random stalls on both sides and one long output hold-off.");
		if (mismatches == 0)
			$display("tb_dda_line_rasterizer: done, clean");
		else
			$display("tb_dda_line_rasterizer: done, errors");
		$finish;
	end

endmodule
